>>> design/rso_pkg.sv
// ----------------------------------------------------------------------------
// rso_pkg
// Shared types and constants for the riffle shuffle order block.
// ----------------------------------------------------------------------------
`default_nettype none

package rso_pkg;

   localparam int SIZE_W  = 9;
   localparam int COUNT_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PASS,
      ST_FLUSH,
      ST_END
   } state_type;

endpackage

`default_nettype wire

>>> design/rso_bank.sv
// ----------------------------------------------------------------------------
// rso_bank
// Deck storage bank: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rso_bank #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int DW    = 8
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] bank_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         bank_ff[waddr] <= wdata;
      end
      rd_data_ff <= bank_ff[raddr];
   end

   assign rdata = rd_data_ff;

endmodule

`default_nettype wire

>>> design/rso_ctrl.sv
// ----------------------------------------------------------------------------
// rso_ctrl
// Sequencer: loads the identity deck, runs ping-pong shuffle passes between
// the two banks, checks order on the fly and counts passes.
// ----------------------------------------------------------------------------
`default_nettype none

module rso_ctrl #(
   parameter int DECK_MAX = 256,
   parameter int AW       = 8,
   parameter int NW       = 9
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rso_pkg::SIZE_W-1:0]  req_deck_size,
   output logic                             busy,
   output logic                             we0,
   output logic                             we1,
   output logic      [AW-1:0]               waddr,
   output logic      [AW-1:0]               wdata,
   output logic      [AW-1:0]               raddr,
   input  wire logic [AW-1:0]               rdata0,
   input  wire logic [AW-1:0]               rdata1,
   output logic                             rsp_valid,
   output logic      [rso_pkg::COUNT_W-1:0] rsp_shuffle_count,
   output logic                             rsp_count_saturated
);

   import rso_pkg::*;

   localparam int CW = (NW > SIZE_W) ? NW : SIZE_W;

   state_type          state_ff, state_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [NW-1:0]      k_ff, k_in;
   logic               sel_ff, sel_in;
   logic               wr_vld_ff, wr_vld_in;
   logic [AW-1:0]      wr_addr_ff, wr_addr_in;
   logic               order_ok_ff, order_ok_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic               accept;
   logic [CW-1:0]      size_ext;
   logic [NW-1:0]      size_clamped;
   logic [NW-1:0]      half;
   logic [NW-1:0]      src;
   logic [AW-1:0]      src_data;
   logic [COUNT_W-1:0] count_inc;

   assign accept   = start && (state_ff == ST_IDLE);
   assign size_ext = CW'(req_deck_size);
   assign size_clamped = (size_ext > CW'(DECK_MAX)) ? NW'(DECK_MAX) : NW'(size_ext);
   assign half     = n_ff >> 1;
   // back half lands on even slots, front half on odd slots
   assign src      = k_ff[0] ? (k_ff >> 1) : (half + (k_ff >> 1));
   assign src_data = sel_ff ? rdata1 : rdata0;
   assign count_inc = count_ff + COUNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (size_clamped == '0) ? ST_PASS : ST_LOAD;
            end
         end
         ST_LOAD: begin
            if ((k_ff + NW'(1)) == n_ff) begin
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            if (k_ff == n_ff) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_END;
         end
         ST_END: begin
            if (order_ok_ff || (count_inc == COUNT_MAX)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_PASS;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      n_in         = n_ff;
      k_in         = k_ff;
      sel_in       = sel_ff;
      wr_vld_in    = 1'b0;
      wr_addr_in   = wr_addr_ff;
      order_ok_in  = order_ok_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      rsp_sat_in   = rsp_sat_ff;
      we0          = 1'b0;
      we1          = 1'b0;
      waddr        = wr_addr_ff;
      wdata        = src_data;
      raddr        = AW'(src);

      // write stage of the pass: store the fetched card and check its slot
      if (wr_vld_ff) begin
         we0         = sel_ff;
         we1         = !sel_ff;
         order_ok_in = order_ok_ff && (src_data == wr_addr_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in        = size_clamped;
               k_in        = '0;
               sel_in      = 1'b0;
               count_in    = '0;
               order_ok_in = 1'b1;
            end
         end
         ST_LOAD: begin
            we0   = 1'b1;
            waddr = AW'(k_ff);
            wdata = AW'(k_ff);
            k_in  = ((k_ff + NW'(1)) == n_ff) ? '0 : (k_ff + NW'(1));
         end
         ST_PASS: begin
            if (k_ff != n_ff) begin
               wr_vld_in  = 1'b1;
               wr_addr_in = AW'(k_ff);
               k_in       = k_ff + NW'(1);
            end
         end
         ST_FLUSH: begin
         end
         ST_END: begin
            count_in = count_inc;
            if (order_ok_ff || (count_inc == COUNT_MAX)) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_inc;
               rsp_sat_in   = !order_ok_ff;
            end else begin
               // swap banks and run another pass
               sel_in      = !sel_ff;
               k_in        = '0;
               order_ok_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         wr_vld_ff    <= wr_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      k_ff         <= k_in;
      sel_ff       <= sel_in;
      wr_addr_ff   <= wr_addr_in;
      order_ok_ff  <= order_ok_in;
      rsp_count_ff <= rsp_count_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_shuffle_count   = rsp_count_ff;
   assign rsp_count_saturated = rsp_sat_ff;

endmodule

`default_nettype wire

>>> design/riffle_shuffle_order_top.sv
// ----------------------------------------------------------------------------
// riffle_shuffle_order_top
// Counts the perfect riffle shuffles that restore a deck of n cards.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_deck_size and raise start while busy is low; that cycle's
//   rising edge is the transfer. Sizes above DECK_MAX are clamped to it,
//   size 0 answers 1. busy stays high until the result is ready.
//   The result comes on rsp_shuffle_count / rsp_count_saturated with a
//   one-cycle rsp_valid strobe; it must be taken in that cycle.
//   count_saturated marks a search stopped at 65535 passes.
// Sequence:
//   The identity deck is loaded first. Each shuffle pass then reads one
//   card per cycle through the single read port of the source bank,
//   drains the last write and passes through a flush state and a
//   decision state. busy stays high from the transfer through the last
//   pass and drops in the strobe cycle. The two banks swap roles each
//   pass, so no copy-back is needed.
//   One item is in work at a time; the next start may follow the strobe
//   cycle directly.
// Reset:
//   Synchronous reset returns the sequencer to idle and drops the strobe.
//   Bank contents are not cleared; every entry read is written first.
// ----------------------------------------------------------------------------
`default_nettype none

module riffle_shuffle_order_top #(
   parameter int DECK_MAX = 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rso_pkg::SIZE_W-1:0]  req_deck_size,
   output logic                             busy,
   output logic                             rsp_valid,
   output logic      [rso_pkg::COUNT_W-1:0] rsp_shuffle_count,
   output logic                             rsp_count_saturated
);

   import rso_pkg::*;

   localparam int AW = $clog2(DECK_MAX);
   localparam int NW = $clog2(DECK_MAX + 1);

   logic          we0;
   logic          we1;
   logic [AW-1:0] waddr;
   logic [AW-1:0] wdata;
   logic [AW-1:0] raddr;
   logic [AW-1:0] rdata0;
   logic [AW-1:0] rdata1;

   rso_ctrl #(
      .DECK_MAX (DECK_MAX),
      .AW       (AW),
      .NW       (NW)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .req_deck_size       (req_deck_size),
      .busy                (busy),
      .we0                 (we0),
      .we1                 (we1),
      .waddr               (waddr),
      .wdata               (wdata),
      .raddr               (raddr),
      .rdata0              (rdata0),
      .rdata1              (rdata1),
      .rsp_valid           (rsp_valid),
      .rsp_shuffle_count   (rsp_shuffle_count),
      .rsp_count_saturated (rsp_count_saturated)
   );

   rso_bank #(
      .DEPTH (DECK_MAX),
      .AW    (AW),
      .DW    (AW)
   ) u_bank0 (
      .clock (clock),
      .we    (we0),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata0)
   );

   rso_bank #(
      .DEPTH (DECK_MAX),
      .AW    (AW),
      .DW    (AW)
   ) u_bank1 (
      .clock (clock),
      .we    (we1),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata1)
   );

endmodule

`default_nettype wire

>>> design/rso_checker.sv
// ----------------------------------------------------------------------------
// rso_checker
// Port-level checks for the riffle shuffle order block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rso_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_valid,
   input wire logic [rso_pkg::COUNT_W-1:0] rsp_shuffle_count,
   input wire logic                        rsp_count_saturated
);

   import rso_pkg::*;

   // a transfer always starts a search
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer did not raise busy");

   // the search ends exactly when its result shows up
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_sat_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count_saturated) |-> (rsp_shuffle_count == COUNT_MAX))
      else $error("saturated result below the count limit");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_shuffle_count != '0))
      else $error("zero shuffle count");

endmodule

bind riffle_shuffle_order_top rso_checker u_rso_checker (.*);

`default_nettype wire
